[rtl/odw_pkg.sv]
// Shared types, widths and constants of the odometer digit wheel drive.
`timescale 1ns / 1ps
`default_nettype none

package odw_pkg;

    // Field widths
    localparam int unsigned ANGLE_W   = 24;
    localparam int unsigned SCALE_W   = 24;
    localparam int unsigned MAG_W     = 19;
    localparam int unsigned PROD_W    = MAG_W + SCALE_W;
    localparam int unsigned WHOLE_W   = 20;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned WHEELS    = 6;

    // Arithmetic constants
    localparam logic [ANGLE_W:0]   GLITCH_LIMIT = 25'd327680;
    localparam int unsigned        PRODUCT_FRAC = 40;
    localparam logic [WHOLE_W-1:0] ODO_MODULUS  = 20'd1000000;
    localparam logic [SCALE_W-1:0] RECIP_RESET  = 24'd5866163;

    // Parameter defaults
    localparam int unsigned DIGIT_COUNT_DEF   = 6;
    localparam int unsigned FRACTION_BITS_DEF = 24;

    // Configuration port
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_SCALE  = 1'b0;
    localparam logic        REG_START  = 1'b1;

    // Stream widths
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 56;

    // Decimal split: floor(x / 10^(k+1)) = (x * DEC_RECIP[k]) >> DEC_SHIFT[k], exact for 20 bits
    localparam int unsigned DEC_DIVS  = 5;
    localparam int unsigned RECIP_W   = 21;
    localparam int unsigned DEC_PROD_W = WHOLE_W + RECIP_W;
    localparam int unsigned DEC_SHIFT [DEC_DIVS] = '{24, 27, 30, 34, 37};
    localparam logic [RECIP_W-1:0] DEC_RECIP [DEC_DIVS] = '{
        21'(((64'd1 << 24) + 64'd9) / 64'd10),
        21'(((64'd1 << 27) + 64'd99) / 64'd100),
        21'(((64'd1 << 30) + 64'd999) / 64'd1000),
        21'(((64'd1 << 34) + 64'd9999) / 64'd10000),
        21'(((64'd1 << 37) + 64'd99999) / 64'd100000)
    };

    typedef logic [DIGIT_W-1:0] t_digit;

    // Load of the start reading into the accumulator
    typedef struct packed {
        logic               load;
        logic [WHOLE_W-1:0] value;
    } t_start_load;

    // One result transaction
    typedef struct packed {
        logic [WHOLE_W-1:0]             disp;
        logic                           absm;
        logic [WHEELS-1:0]              mask;
        logic [WHEELS-1:0][DIGIT_W-1:0] step;
    } t_wheel_res;

endpackage

`default_nettype wire

[rtl/odw_front.sv]
// Input register, angle difference with glitch rejection, and travel scaling.
`timescale 1ns / 1ps
`default_nettype none

module odw_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_vld,
    input  wire logic [odw_pkg::ANGLE_W-1:0]   i_angle,
    input  wire logic [odw_pkg::SCALE_W-1:0]   i_scale,
    output logic                               o_vld,
    output logic [odw_pkg::PROD_W-1:0]         o_prod
);

    logic                          r_a_vld;
    logic [odw_pkg::ANGLE_W-1:0]   r_a_angle;
    logic [odw_pkg::ANGLE_W-1:0]   r_last_angle;
    logic                          r_b_vld;
    logic [odw_pkg::MAG_W-1:0]     r_b_mag;
    logic                          r_c_vld;
    logic [odw_pkg::PROD_W-1:0]    r_c_prod;

    logic signed [odw_pkg::ANGLE_W:0] w_diff;
    logic [odw_pkg::ANGLE_W:0]        w_abs;
    logic [odw_pkg::MAG_W-1:0]        n_mag;

    // Travel magnitude; drop anything beyond the glitch limit
    always_comb begin
        w_diff = $signed({r_a_angle[odw_pkg::ANGLE_W-1], r_a_angle})
               - $signed({r_last_angle[odw_pkg::ANGLE_W-1], r_last_angle});
        w_abs  = w_diff[odw_pkg::ANGLE_W] ? (~w_diff + 1'b1) : w_diff;
        n_mag  = (w_abs > odw_pkg::GLITCH_LIMIT) ? '0 : w_abs[odw_pkg::MAG_W-1:0];
    end

    // Stage valids and last angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld      <= 1'b0;
            r_b_vld      <= 1'b0;
            r_c_vld      <= 1'b0;
            r_last_angle <= '0;
        end else if (i_adv) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            if (r_a_vld) begin
                r_last_angle <= r_a_angle;
            end
        end
    end

    // Payload stages: capture, magnitude, product
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_angle <= i_angle;
            r_b_mag   <= n_mag;
            r_c_prod  <= odw_pkg::PROD_W'(r_b_mag) * odw_pkg::PROD_W'(i_scale);
        end
    end

    assign o_vld  = r_c_vld;
    assign o_prod = r_c_prod;

endmodule

`default_nettype wire

[rtl/odw_accum.sv]
// Distance accumulator: binary fraction plus whole part kept modulo one million.
`timescale 1ns / 1ps
`default_nettype none

module odw_accum #(
    parameter int unsigned FRACTION_BITS = odw_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_vld,
    input  wire logic [odw_pkg::PROD_W-1:0]    i_prod,
    input  wire odw_pkg::t_start_load          i_start,
    output logic                               o_vld,
    output logic [odw_pkg::WHOLE_W-1:0]        o_whole
);

    localparam int unsigned PROD_SHIFT = odw_pkg::PRODUCT_FRAC - FRACTION_BITS;
    localparam int unsigned INC_W      = odw_pkg::PROD_W - PROD_SHIFT;
    localparam int unsigned SUM_W      = INC_W + 1;
    localparam int unsigned CARRY_W    = SUM_W - FRACTION_BITS;

    logic [FRACTION_BITS-1:0]      r_frac;
    logic [odw_pkg::WHOLE_W-1:0]   r_whole;
    logic                          r_d_vld;
    logic [odw_pkg::WHOLE_W-1:0]   r_d_whole;

    logic [INC_W-1:0]              w_inc;
    logic [SUM_W-1:0]              w_sum;
    logic [CARRY_W-1:0]            w_carry;
    logic [odw_pkg::WHOLE_W-1:0]   w_whole_inc;
    logic [odw_pkg::WHOLE_W-1:0]   n_whole;
    logic [odw_pkg::WHOLE_W-1:0]   w_start_mod;

    // Add the scaled travel, carry into the whole part, wrap once
    always_comb begin
        w_inc       = INC_W'(i_prod >> PROD_SHIFT);
        w_sum       = SUM_W'(r_frac) + SUM_W'(w_inc);
        w_carry     = w_sum[SUM_W-1:FRACTION_BITS];
        w_whole_inc = r_whole + odw_pkg::WHOLE_W'(w_carry);
        n_whole     = (w_whole_inc >= odw_pkg::ODO_MODULUS)
                    ? (w_whole_inc - odw_pkg::ODO_MODULUS) : w_whole_inc;
        w_start_mod = (i_start.value >= odw_pkg::ODO_MODULUS)
                    ? (i_start.value - odw_pkg::ODO_MODULUS) : i_start.value;
    end

    // Accumulator state; a start load replaces the whole part only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac  <= '0;
            r_whole <= '0;
            r_d_vld <= 1'b0;
        end else begin
            if (i_start.load) begin
                r_whole <= w_start_mod;
            end else if (i_adv && i_vld) begin
                r_whole <= n_whole;
                r_frac  <= w_sum[FRACTION_BITS-1:0];
            end
            if (i_adv) begin
                r_d_vld <= i_vld;
            end
        end
    end

    // Hand the new reading down the pipe
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d_whole <= n_whole;
        end
    end

    assign o_vld   = r_d_vld;
    assign o_whole = r_d_whole;

`ifndef SYNTH
    a_whole_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_whole < odw_pkg::ODO_MODULUS)
        else $error("accumulator whole part left the odometer range");
`endif

endmodule

`default_nettype wire

[rtl/odw_decsplit.sv]
// Two-stage decimal split of the reading by constant reciprocal multiplies.
`timescale 1ns / 1ps
`default_nettype none

module odw_decsplit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_vld,
    input  wire logic [odw_pkg::WHOLE_W-1:0]   i_whole,
    output logic                               o_vld,
    output odw_pkg::t_digit                    o_digits [odw_pkg::WHEELS],
    output logic [odw_pkg::WHOLE_W-1:0]        o_whole
);

    logic                          r_e_vld;
    logic [odw_pkg::WHOLE_W-1:0]   r_e_whole;
    logic [odw_pkg::WHOLE_W-1:0]   r_e_q [odw_pkg::DEC_DIVS];
    logic                          r_f_vld;
    logic [odw_pkg::WHOLE_W-1:0]   r_f_whole;
    odw_pkg::t_digit               r_f_dig [odw_pkg::WHEELS];

    logic [odw_pkg::DEC_PROD_W-1:0] w_prod [odw_pkg::DEC_DIVS];
    logic [odw_pkg::WHOLE_W-1:0]    n_q    [odw_pkg::DEC_DIVS];
    logic [odw_pkg::WHOLE_W-1:0]    w_hi   [odw_pkg::WHEELS];
    logic [odw_pkg::WHOLE_W-1:0]    w_lo   [odw_pkg::WHEELS];
    odw_pkg::t_digit                n_dig  [odw_pkg::WHEELS];

    // Quotients by 10, 100, ... 100000
    always_comb begin
        for (int k = 0; k < odw_pkg::DEC_DIVS; k++) begin
            w_prod[k] = odw_pkg::DEC_PROD_W'(i_whole)
                      * odw_pkg::DEC_PROD_W'(odw_pkg::DEC_RECIP[k]);
            n_q[k]    = odw_pkg::WHOLE_W'(w_prod[k] >> odw_pkg::DEC_SHIFT[k]);
        end
    end

    // Digit at place p is quotient(p) minus ten times quotient(p+1); wheel 0 is the top place
    always_comb begin
        for (int j = 0; j < odw_pkg::WHEELS; j++) begin
            if (j == odw_pkg::WHEELS - 1) begin
                w_hi[j] = r_e_whole;
            end else begin
                w_hi[j] = r_e_q[odw_pkg::WHEELS - 2 - j];
            end
            if (j == 0) begin
                w_lo[j] = '0;
            end else begin
                w_lo[j] = r_e_q[odw_pkg::WHEELS - 1 - j];
            end
            n_dig[j] = odw_pkg::DIGIT_W'(w_hi[j] - ((w_lo[j] << 3) + (w_lo[j] << 1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (i_adv) begin
            r_e_vld <= i_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_e_whole <= i_whole;
            r_f_whole <= r_e_whole;
            for (int k = 0; k < odw_pkg::DEC_DIVS; k++) begin
                r_e_q[k] <= n_q[k];
            end
            for (int j = 0; j < odw_pkg::WHEELS; j++) begin
                r_f_dig[j] <= n_dig[j];
            end
        end
    end

    assign o_vld    = r_f_vld;
    assign o_whole  = r_f_whole;
    assign o_digits = r_f_dig;

endmodule

`default_nettype wire

[rtl/odw_wheels.sv]
// Wheel tracking: compare new digits with shown ones, build the result register.
`timescale 1ns / 1ps
`default_nettype none

module odw_wheels #(
    parameter int unsigned DIGIT_COUNT = odw_pkg::DIGIT_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_vld,
    input  wire odw_pkg::t_digit               i_digits [odw_pkg::WHEELS],
    input  wire logic [odw_pkg::WHOLE_W-1:0]   i_whole,
    output logic                               o_vld,
    output odw_pkg::t_wheel_res                o_res
);

    localparam int unsigned DIGIT_EFF =
        (DIGIT_COUNT > odw_pkg::WHEELS) ? odw_pkg::WHEELS : DIGIT_COUNT;
    localparam logic [odw_pkg::WHEELS-1:0] PRESENT =
        {odw_pkg::WHEELS{1'b1}} << (odw_pkg::WHEELS - DIGIT_EFF);

    odw_pkg::t_digit               r_shown [odw_pkg::WHEELS];
    logic [odw_pkg::WHEELS-1:0]    r_valid;
    logic                          r_out_vld;
    odw_pkg::t_wheel_res           r_res;

    odw_pkg::t_wheel_res           n_res;
    logic [odw_pkg::WHEELS-1:0]    n_valid;

    // Absolute digit on first sight, forward steps when the digit moved
    always_comb begin
        n_res      = '0;
        n_res.disp = i_whole;
        n_valid    = r_valid;
        for (int j = 0; j < odw_pkg::WHEELS; j++) begin
            if (PRESENT[j]) begin
                if (!r_valid[j]) begin
                    n_res.step[j] = i_digits[j];
                    n_res.mask[j] = 1'b1;
                    n_res.absm    = 1'b1;
                    n_valid[j]    = 1'b1;
                end else if (r_shown[j] != i_digits[j]) begin
                    n_res.mask[j] = 1'b1;
                    if (i_digits[j] >= r_shown[j]) begin
                        n_res.step[j] = i_digits[j] - r_shown[j];
                    end else begin
                        n_res.step[j] = i_digits[j] + odw_pkg::DIGIT_W'(10) - r_shown[j];
                    end
                end
            end
        end
    end

    // Wheel state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_out_vld <= 1'b0;
            for (int j = 0; j < odw_pkg::WHEELS; j++) begin
                r_shown[j] <= '0;
            end
        end else if (i_adv) begin
            r_out_vld <= i_vld;
            if (i_vld) begin
                r_valid <= n_valid;
                for (int j = 0; j < odw_pkg::WHEELS; j++) begin
                    if (PRESENT[j]) begin
                        r_shown[j] <= i_digits[j];
                    end
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_adv && i_vld) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_out_vld;
    assign o_res = r_res;

`ifndef SYNTH
    a_abs_has_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.absm) |-> (r_res.mask != '0))
        else $error("absolute result without any wheel driven");
    a_absent_never_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid & ~PRESENT) == '0)
        else $error("absent wheel marked valid");
    a_valid_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (($past(r_valid) & ~r_valid) == '0))
        else $error("wheel valid bit cleared outside reset");
    a_display_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_res.disp < odw_pkg::ODO_MODULUS))
        else $error("displayed reading out of range");
`endif

endmodule

`default_nettype wire

[rtl/odometer_digit_wheel_drive.sv]
// Top level of the odometer digit wheel drive: stream ports, register port, pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Takes one signed Q8.16 wheel-angle sample per transaction and returns one result
// transaction per sample: forward steps (or absolute digits on the first update) for six
// odometer wheels, the mask of wheels to drive, and the reading modulo one million. The
// pipeline accepts a sample every cycle while o_s_tready is high; each result passes the
// front, accumulator, decimal-split and result registers. Throughput is one transaction per
// cycle, set by the accumulator loop (one add, carry and wrap per cycle). When the result is
// not taken, the whole pipeline holds and o_s_tready drops. Registers: 0x0 distance scale
// (Q0.24), 0x4 start reading; write them only while no transaction is in flight.
module odometer_digit_wheel_drive #(
    parameter int unsigned DIGIT_COUNT   = odw_pkg::DIGIT_COUNT_DEF,
    parameter int unsigned FRACTION_BITS = odw_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Sample stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [odw_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // [23:0] wheel_angle
    // Result stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [3:0] step_d0, [7:4] step_d1, [11:8] step_d2, [15:12] step_d3, [19:16] step_d4,
    // [23:20] step_d5, [29:24] changed_mask, [49:30] display_value, [55:50] zero
    output logic [odw_pkg::OUT_TDATA_W-1:0]         o_m_tdata,
    output logic                                    o_m_tuser,   // [0] absolute_mode
    // Register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [odw_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [odw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [odw_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready
);

    logic [odw_pkg::SCALE_W-1:0]   r_scale;
    logic [odw_pkg::WHOLE_W-1:0]   r_start;

    logic                          w_adv;
    logic                          w_cfg_wr;
    odw_pkg::t_start_load          w_start;
    logic                          w_c_vld;
    logic [odw_pkg::PROD_W-1:0]    w_c_prod;
    logic                          w_d_vld;
    logic [odw_pkg::WHOLE_W-1:0]   w_d_whole;
    logic                          w_f_vld;
    odw_pkg::t_digit               w_f_dig [odw_pkg::WHEELS];
    logic [odw_pkg::WHOLE_W-1:0]   w_f_whole;
    logic                          w_out_vld;
    odw_pkg::t_wheel_res           w_res;

    // Advance the pipeline whenever the result register is free or being taken
    assign w_adv      = !w_out_vld || i_m_tready;
    assign o_s_tready = w_adv;

    // Register writes
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= odw_pkg::RECIP_RESET;
            r_start <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                odw_pkg::REG_SCALE: r_scale <= pwdata[odw_pkg::SCALE_W-1:0];
                odw_pkg::REG_START: r_start <= pwdata[odw_pkg::WHOLE_W-1:0];
                default:            r_scale <= r_scale;
            endcase
        end
    end

    assign w_start.load  = w_cfg_wr && (paddr[2] == odw_pkg::REG_START);
    assign w_start.value = pwdata[odw_pkg::WHOLE_W-1:0];

    // Register reads
    always_comb begin
        unique case (paddr[2])
            odw_pkg::REG_SCALE: prdata = odw_pkg::APB_DATA_W'(r_scale);
            odw_pkg::REG_START: prdata = odw_pkg::APB_DATA_W'(r_start);
            default:            prdata = '0;
        endcase
    end

    odw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (i_s_tvalid),
        .i_angle (i_s_tdata[odw_pkg::ANGLE_W-1:0]),
        .i_scale (r_scale),
        .o_vld   (w_c_vld),
        .o_prod  (w_c_prod)
    );

    odw_accum #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_c_vld),
        .i_prod  (w_c_prod),
        .i_start (w_start),
        .o_vld   (w_d_vld),
        .o_whole (w_d_whole)
    );

    odw_decsplit u_decsplit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_vld    (w_d_vld),
        .i_whole  (w_d_whole),
        .o_vld    (w_f_vld),
        .o_digits (w_f_dig),
        .o_whole  (w_f_whole)
    );

    odw_wheels #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_wheels (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_vld    (w_f_vld),
        .i_digits (w_f_dig),
        .i_whole  (w_f_whole),
        .o_vld    (w_out_vld),
        .o_res    (w_res)
    );

    // Pack the result transaction
    assign o_m_tvalid = w_out_vld;
    assign o_m_tdata  = odw_pkg::OUT_TDATA_W'({w_res.disp, w_res.mask, w_res.step});
    assign o_m_tuser  = w_res.absm;

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the odometer digit wheel drive: angle stream in, wheel steps out.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam logic [odw_pkg::ADDR_W-1:0] ADDR_SCALE = 3'h0;
    localparam logic [odw_pkg::ADDR_W-1:0] ADDR_START = 3'h4;
    localparam logic [23:0] SCALE_DEFAULT = 24'd5866163;
    localparam logic [23:0] SCALE_MAX     = 24'hFFFFFF;
    localparam int unsigned TRAVEL_LIMIT  = 327680;
    localparam int unsigned READING_WRAP  = 1000000;
    localparam int unsigned WHEEL_WEIGHT [6] = '{100000, 10000, 1000, 100, 10, 1};

    logic                                i_clk      = 1'b0;
    logic                                i_rst_n    = 1'b0;
    logic                                i_s_tvalid = 1'b0;
    logic                                o_s_tready;
    logic [odw_pkg::IN_TDATA_W-1:0]      i_s_tdata  = '0;
    logic                                o_m_tvalid;
    logic                                i_m_tready = 1'b0;
    logic [odw_pkg::OUT_TDATA_W-1:0]     o_m_tdata;
    logic                                o_m_tuser;
    logic                                psel       = 1'b0;
    logic                                penable    = 1'b0;
    logic                                pwrite     = 1'b0;
    logic [odw_pkg::ADDR_W-1:0]          paddr      = '0;
    logic [odw_pkg::APB_DATA_W-1:0]      pwdata     = '0;
    logic [odw_pkg::APB_DATA_W-1:0]      prdata;
    logic                                pready;

    // One predicted result transaction
    typedef struct packed {
        logic [19:0]     reading;
        logic            absolute;
        logic [5:0]      mask;
        logic [5:0][3:0] steps;
    } t_wheel_result;

    t_wheel_result pending_readings[$];

    // Predicted registers and odometer state
    logic [23:0] scale_q;
    logic [19:0] start_q;
    logic [23:0] last_angle_q;
    int unsigned whole_q;
    logic [23:0] fraction_q;
    logic [3:0]  shown_q [6];
    logic [5:0]  valid_q;

    int unsigned valid_idle_pct = 19;
    int unsigned ready_idle_pct = 53;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    odometer_digit_wheel_drive uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("odometer_digit_wheel_drive verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    function automatic void reset_odometer_model();
        scale_q      = SCALE_DEFAULT;
        start_q      = '0;
        last_angle_q = '0;
        whole_q      = 0;
        fraction_q   = '0;
        valid_q      = '0;
        for (int j = 0; j < 6; j++) shown_q[j] = '0;
    endfunction

    function automatic void apply_register(input logic [odw_pkg::ADDR_W-1:0] addr,
                                           input logic [31:0] data);
        if (addr == ADDR_SCALE) begin
            scale_q = data[23:0];
        end else if (addr == ADDR_START) begin
            // Reload the whole part only; fraction and shown digits persist
            start_q = data[19:0];
            whole_q = 32'(data[19:0]) % READING_WRAP;
        end
    endfunction

    // Advance the odometer by one angle sample and queue the wheel drive it causes
    function automatic void advance_odometer(input logic [23:0] angle);
        logic signed [24:0] delta;
        longint unsigned    travel;
        longint unsigned    total;
        int unsigned        digit;
        t_wheel_result      r;
        delta  = $signed({angle[23], angle}) - $signed({last_angle_q[23], last_angle_q});
        travel = (delta < 0) ? 64'(-delta) : 64'(delta);
        // Reject wrap glitches but still record the angle
        if (travel > TRAVEL_LIMIT) travel = 0;
        last_angle_q = angle;
        total        = 64'(fraction_q) + ((travel * 64'(scale_q)) >> 16);
        fraction_q   = total[23:0];
        whole_q      = (whole_q + 32'(total >> 24)) % READING_WRAP;
        r         = '0;
        r.reading = 20'(whole_q);
        for (int j = 0; j < 6; j++) begin
            digit = (whole_q / WHEEL_WEIGHT[j]) % 10;
            if (!valid_q[j]) begin
                r.steps[j]  = 4'(digit);
                r.mask[j]   = 1'b1;
                r.absolute  = 1'b1;
                valid_q[j]  = 1'b1;
                shown_q[j]  = 4'(digit);
            end else if (shown_q[j] != 4'(digit)) begin
                r.steps[j]  = 4'((digit + 10 - shown_q[j]) % 10);
                r.mask[j]   = 1'b1;
                shown_q[j]  = 4'(digit);
            end
        end
        pending_readings.insert(pending_readings.size(), r);
    endfunction

    // Toggle the result-side ready at random
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= ready_idle_pct);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_wheel_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("result with nothing pending", o_m_tdata, 0);
            end else begin
                want = pending_readings.pop_front();
                for (int j = 0; j < 6; j++)
                    if (o_m_tdata[4*j +: 4] !== want.steps[j])
                        report_mismatch($sformatf("step_d%0d", j), o_m_tdata[4*j +: 4],
                                        want.steps[j]);
                if (o_m_tdata[29:24] !== want.mask)
                    report_mismatch("changed_mask", o_m_tdata[29:24], want.mask);
                if (o_m_tdata[49:30] !== want.reading)
                    report_mismatch("display_value", o_m_tdata[49:30], want.reading);
                if (o_m_tdata[55:50] !== 6'd0)
                    report_mismatch("tdata padding", o_m_tdata[55:50], 0);
                if (o_m_tuser !== want.absolute)
                    report_mismatch("absolute_mode", o_m_tuser, want.absolute);
            end
        end
    end

    // Send one angle sample; called at a falling edge, returns at a falling edge
    task automatic send_angle(input logic [23:0] angle);
        while ($urandom_range(99) < valid_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= angle;
        do @(posedge i_clk); while (!o_s_tready);
        advance_odometer(angle);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every predicted result has arrived
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Read a register and check it; returns at a falling edge after the bus goes idle
    task automatic read_register(input logic [odw_pkg::ADDR_W-1:0] addr,
                                 input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) report_mismatch("register readback", prdata, want);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Write a register, then read it back in the next transfer
    task automatic write_register(input logic [odw_pkg::ADDR_W-1:0] addr,
                                  input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_register(addr, data);
        @(negedge i_clk);
        read_register(addr, (addr == ADDR_SCALE) ? 32'(scale_q) : 32'(start_q));
    endtask

    // Start readings near digit rollovers, above the wrap, or anywhere
    function automatic logic [31:0] pick_start();
        case ($urandom_range(3))
            0: return 32'($urandom_range(20'hFFFFF));
            1: return 32'(999999 - $urandom_range(40));
            2: return 32'($urandom_range(9) * 100000 + 99990 + $urandom_range(9));
            default: return 32'(1000000 + $urandom_range(48575));
        endcase
    endfunction

    // Mostly legal moves, some at the glitch boundary, the rest arbitrary angles
    function automatic logic [23:0] next_angle(input logic [23:0] base);
        int          delta;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            delta = int'($urandom_range(2 * TRAVEL_LIMIT)) - int'(TRAVEL_LIMIT);
            return base + 24'(delta);
        end else if (pick < 80) begin
            delta = int'(TRAVEL_LIMIT) + int'($urandom_range(1));
            return $urandom_range(1) ? base + 24'(delta) : base - 24'(delta);
        end
        return 24'($urandom_range(24'hFFFFFF));
    endfunction

    // Check reset values and the first, absolute update
    task automatic test_reset_state();
        read_register(ADDR_SCALE, 32'(SCALE_DEFAULT));
        read_register(ADDR_START, 32'd0);
        send_angle(24'h000000);
        send_angle(24'h000100);
        wait_drained();
    endtask

    // Exercise the glitch limit and jumps across the angle range
    task automatic test_glitch_and_wrap();
        write_register(ADDR_SCALE, 32'(SCALE_MAX));
        send_angle(24'h000000);
        send_angle(24'h050000);   // exactly at the limit, counted
        send_angle(24'h0A0001);   // one past the limit, dropped
        send_angle(24'h7FFFFF);
        send_angle(24'h800000);   // across the signed range, dropped
        send_angle(24'h850000);
        send_angle(24'h800000);   // backward travel counts forward
        send_angle(24'hFFFFFF);
        send_angle(24'h000000);
        wait_drained();
    endtask

    // Zero scale adds no distance for full-size moves; minimum scale then gets one move past the glitch limit
    task automatic test_zero_scale();
        write_register(ADDR_SCALE, 32'd0);
        send_angle(24'h040000);
        send_angle(24'h000000);
        send_angle(24'hFC0000);
        wait_drained();
        write_register(ADDR_SCALE, 32'd1);
        send_angle(24'h050000);
        wait_drained();
    endtask

    // Reload the start reading, above the wrap and just below it
    task automatic test_start_reload();
        write_register(ADDR_START, 32'hFFFFF);
        send_angle(24'h050000);
        wait_drained();
        write_register(ADDR_SCALE, 32'(SCALE_MAX));
        write_register(ADDR_START, 32'd999999);
        send_angle(24'h0A0000);
        send_angle(24'h0F0000);
        send_angle(24'h140000);
        wait_drained();
        write_register(ADDR_START, 32'd0);
        send_angle(24'h140000);
        wait_drained();
    endtask

    // Random angle stream with periodic start reloads
    task automatic test_random_angles(input int unsigned count, input int unsigned valid_pct,
                                      input int unsigned ready_pct, input logic [23:0] scale);
        valid_idle_pct = valid_pct;
        ready_idle_pct = ready_pct;
        write_register(ADDR_SCALE, 32'(scale));
        write_register(ADDR_START, pick_start());
        for (int i = 0; i < count; i++) begin
            if (i % 48 == 47) begin
                wait_drained();
                write_register(ADDR_START, pick_start());
            end
            send_angle(next_angle(last_angle_q));
        end
        wait_drained();
    endtask

    initial begin
        reset_odometer_model();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_glitch_and_wrap();
        test_zero_scale();
        test_start_reload();

        test_random_angles(190, 19, 53, SCALE_DEFAULT);
        test_random_angles(190, 19, 53, SCALE_MAX);
        test_random_angles(190, 53, 19, 24'($urandom_range(24'hFFFFFF)));
        test_random_angles(190, 53, 19, SCALE_MAX);
        test_random_angles(190, 0, 0, 24'($urandom_range(24'hFFFFFF)));
        test_random_angles(190, 0, 0, SCALE_DEFAULT);

        // Let the pipeline settle and catch any stray results
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("odometer_digit_wheel_drive verification clean");
        end else begin
            $display("odometer_digit_wheel_drive verification failed");
        end
        $finish;
    end

endmodule

[odometer_digit_wheel_drive.f]
rtl/odw_pkg.sv
rtl/odw_front.sv
rtl/odw_accum.sv
rtl/odw_decsplit.sv
rtl/odw_wheels.sv
rtl/odometer_digit_wheel_drive.sv
bench/tb.sv
